FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define MDBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define MDBA_ASSERT_IMP(lbl, ante, cons) \
  `MDBA_ASSERT(lbl, (ante) |-> (cons))

`endif

FILE: rtl/mdba_pkg.sv
// ----------------------------------------------------------------------------
// mdba_pkg
// shared types and constants of the multiply, divide and decimal adjust unit
// ----------------------------------------------------------------------------
package mdba_pkg;

  // quotient bits of the divide chain, one cell per bit
  localparam int unsigned QuoW = 9;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_DIV = 3'd1,
    OP_DAA = 3'd2,
    OP_DAS = 3'd3,
    OP_XCN = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] acc_in;
    logic [7:0] x_in;
    logic [7:0] y_in;
    logic       carry_in;
    logic       half_carry_in;
    logic       overflow_in;
  } mdba_in_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] y_out;
    logic       carry_out;
    logic       half_carry_out;
    logic       overflow_out;
    logic       zero_flag;
    logic       negative_flag;
  } mdba_out_t;

  // payload handed from stage to stage
  typedef struct packed {
    logic            is_div;
    logic            is_mul;
    logic            alt;     // quirky formula for y >= 2x
    logic [7:0]      x;
    logic [QuoW-1:0] dvs;     // divisor, 1..256
    logic [QuoW-1:0] rem;     // partial remainder, below dvs
    logic [QuoW-1:0] lq;      // dividend bits left in the msbs, quotient in the lsbs
    logic [7:0]      acc;
    logic [7:0]      y;
    logic            c;
    logic            h;
    logic            v;
  } mdba_stage_t;

endpackage

FILE: rtl/mdba_prep.sv
// ----------------------------------------------------------------------------
// mdba_prep
// entry stage: non-divide results, divide flags and divide setup
// ----------------------------------------------------------------------------
module mdba_prep import mdba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  mdba_in_t    data_i,
  output logic        ready_o,
  output logic        valid_o,
  output mdba_stage_t data_o,
  input  logic        ready_i
);

  logic        valid_q;
  mdba_stage_t data_q, data_d;

  logic [15:0] ya, prod, diff, num;
  logic [7:0]  adj1, adj2;
  logic        alt;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    ya   = {data_i.y_in, data_i.acc_in};
    prod = {8'h00, data_i.y_in} * {8'h00, data_i.acc_in};
    alt  = {1'b0, data_i.y_in} >= {data_i.x_in, 1'b0};
    // only used when alt, then x is at most 127
    diff = ya - {data_i.x_in[6:0], 9'b0};
    num  = alt ? diff : ya;
    adj1 = data_i.acc_in;
    adj2 = data_i.acc_in;

    data_d        = '0;
    data_d.x      = data_i.x_in;
    data_d.alt    = alt;
    data_d.dvs    = alt ? (QuoW'(256) - QuoW'(data_i.x_in)) : QuoW'(data_i.x_in);
    data_d.rem    = QuoW'(num[15:QuoW]);
    data_d.lq     = num[QuoW-1:0];
    data_d.acc    = data_i.acc_in;
    data_d.y      = data_i.y_in;
    data_d.c      = data_i.carry_in;
    data_d.h      = data_i.half_carry_in;
    data_d.v      = data_i.overflow_in;

    case (data_i.operation)
      OP_MUL: begin
        data_d.is_mul = 1'b1;
        data_d.acc    = prod[7:0];
        data_d.y      = prod[15:8];
      end
      OP_DIV: begin
        data_d.is_div = 1'b1;
        data_d.h      = data_i.y_in[3:0] >= data_i.x_in[3:0];
        data_d.v      = data_i.y_in >= data_i.x_in;
      end
      OP_DAA: begin
        if (data_i.carry_in || data_i.acc_in > 8'h99) begin
          adj1     = data_i.acc_in + 8'h60;
          data_d.c = 1'b1;
        end
        adj2 = (data_i.half_carry_in || adj1[3:0] > 4'h9) ? adj1 + 8'h06 : adj1;
        data_d.acc = adj2;
      end
      OP_DAS: begin
        if (!data_i.carry_in || data_i.acc_in > 8'h99) begin
          adj1     = data_i.acc_in - 8'h60;
          data_d.c = 1'b0;
        end
        adj2 = (!data_i.half_carry_in || adj1[3:0] > 4'h9) ? adj1 - 8'h06 : adj1;
        data_d.acc = adj2;
      end
      OP_XCN: begin
        data_d.acc = {data_i.acc_in[3:0], data_i.acc_in[7:4]};
      end
      default: begin
        // unused codes pass everything through
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: rtl/mdba_cell.sv
// ----------------------------------------------------------------------------
// mdba_cell
// one restoring division step: shift in a dividend bit, produce a quotient bit
// ----------------------------------------------------------------------------
module mdba_cell import mdba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  mdba_stage_t data_i,
  output logic        ready_o,
  output logic        valid_o,
  output mdba_stage_t data_o,
  input  logic        ready_i
);

  logic        valid_q;
  mdba_stage_t data_q, data_d;
  logic [QuoW:0] part, sub;
  logic          ge;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    part   = {data_i.rem, data_i.lq[QuoW-1]};
    sub    = part - {1'b0, data_i.dvs};
    ge     = part >= {1'b0, data_i.dvs};
    data_d = data_i;
    data_d.rem = ge ? sub[QuoW-1:0] : part[QuoW-1:0];
    data_d.lq  = {data_i.lq[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: rtl/mdba_post.sv
// ----------------------------------------------------------------------------
// mdba_post
// final stage: divide result mapping, zero and negative flags, output register
// ----------------------------------------------------------------------------
module mdba_post import mdba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  mdba_stage_t data_i,
  output logic        ready_o,
  output logic        valid_o,
  output mdba_out_t   data_o,
  input  logic        stall_i
);

  logic      valid_q;
  mdba_out_t data_q, data_d;
  logic [7:0] acc_fin, y_fin, flag_byte;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    acc_fin = data_i.acc;
    y_fin   = data_i.y;
    if (data_i.is_div) begin
      // quirky case: a = 255 - q, y = x + r, both wrapped
      acc_fin = data_i.alt ? ~data_i.lq[7:0] : data_i.lq[7:0];
      y_fin   = data_i.alt ? data_i.x + data_i.rem[7:0] : data_i.rem[7:0];
    end
    flag_byte = data_i.is_mul ? y_fin : acc_fin;

    data_d.acc_out        = acc_fin;
    data_d.y_out          = y_fin;
    data_d.carry_out      = data_i.c;
    data_d.half_carry_out = data_i.h;
    data_d.overflow_out   = data_i.v;
    data_d.zero_flag      = flag_byte == 8'h00;
    data_d.negative_flag  = flag_byte[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: rtl/mul_div_bcd_adjust_unit.sv
// ----------------------------------------------------------------------------
// mul_div_bcd_adjust_unit
// multiply, divide, decimal adjust and nibble swap for an 8-bit processor core
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid_i / in_stall_o with in_data_i (operation, A, X, Y,
//   carry, half-carry, overflow). a transfer happens on a rising edge with
//   valid high and stall low.
//   output channel: out_valid_o / out_stall_i with out_data_o (new A, new Y,
//   carry, half-carry, overflow, zero, negative).
//   every operation runs through the same pipeline: an entry stage, nine
//   division cells (one quotient bit each) and an output register.
//   throughput is one transfer per cycle while the receiver does not stall;
//   each division cell is one compare and subtract of a 10-bit partial
//   remainder, the multiply sits in the entry stage.
//   when the receiver stalls, the output register holds its result and the
//   stall moves back stage by stage; empty stages still accept, so the input
//   keeps taking transfers until the pipeline is full.
//   reset empties all stages; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mul_div_bcd_adjust_unit import mdba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mdba_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mdba_out_t out_data_o
);

  mdba_stage_t stg [QuoW+1];
  logic        vld [QuoW+1];
  logic        rdy [QuoW+1];
  logic        prep_ready;

  assign in_stall_o = !prep_ready;

  mdba_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .ready_o (prep_ready),
    .valid_o (vld[0]),
    .data_o  (stg[0]),
    .ready_i (rdy[0])
  );

  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    mdba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .data_i  (stg[k]),
      .ready_o (rdy[k]),
      .valid_o (vld[k+1]),
      .data_o  (stg[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  mdba_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[QuoW]),
    .data_i  (stg[QuoW]),
    .ready_o (rdy[QuoW]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .stall_i (out_stall_i)
  );

  // division setup keeps the partial remainder below a nonzero divisor
  `MDBA_ASSERT_IMP(a_div_setup, vld[0] && stg[0].is_div,
                   stg[0].dvs != '0 && stg[0].rem < stg[0].dvs)
  // the last cell still leaves a proper remainder
  `MDBA_ASSERT_IMP(a_div_rem, vld[QuoW] && stg[QuoW].is_div,
                   stg[QuoW].rem < stg[QuoW].dvs)
  // an empty entry stage never pushes back
  `MDBA_ASSERT_IMP(a_no_false_stall, !vld[0], !in_stall_o)

endmodule

FILE: test/mul_div_bcd_adjust_unit_chk.sv
// ----------------------------------------------------------------------------
// mul_div_bcd_adjust_unit_chk
// watches both channels of the arithmetic unit, predicts every result from the
// accepted request and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module mul_div_bcd_adjust_unit_chk import mdba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  mdba_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  mdba_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  mdba_out_t predicted_q[$];

  function automatic mdba_out_t predict_result(input mdba_in_t req);
    mdba_out_t   res;
    logic [7:0]  a;
    logic [7:0]  y;
    logic [7:0]  flag_byte;
    logic        c;
    logic        h;
    logic        v;
    logic [15:0] prod;
    int unsigned ya;
    int unsigned xv;
    int unsigned d;
    int unsigned m;
    a = req.acc_in;
    y = req.y_in;
    c = req.carry_in;
    h = req.half_carry_in;
    v = req.overflow_in;
    xv = req.x_in;
    case (req.operation)
      OP_MUL: begin
        prod = {8'h00, y} * {8'h00, a};
        a = prod[7:0];
        y = prod[15:8];
        flag_byte = y;
      end
      OP_DIV: begin
        ya = {16'h0000, y, a};
        h = (y[3:0] >= req.x_in[3:0]);
        v = (y >= req.x_in);
        if (int'(y) < 2 * xv) begin
          a = 8'(ya / xv);
          y = 8'(ya % xv);
        end else begin
          // quirky path, also taken for a zero divisor
          d = ya - xv * 512;
          m = 256 - xv;
          a = 8'(255 - d / m);
          y = 8'(xv + d % m);
        end
        flag_byte = a;
      end
      OP_DAA: begin
        if (c || a > 8'h99) begin
          a = a + 8'h60;
          c = 1'b1;
        end
        if (h || a[3:0] > 4'h9) a = a + 8'h06;
        flag_byte = a;
      end
      OP_DAS: begin
        if (!c || a > 8'h99) begin
          a = a - 8'h60;
          c = 1'b0;
        end
        if (!h || a[3:0] > 4'h9) a = a - 8'h06;
        flag_byte = a;
      end
      OP_XCN: begin
        a = {a[3:0], a[7:4]};
        flag_byte = a;
      end
      default: begin
        flag_byte = a;
      end
    endcase
    res.acc_out        = a;
    res.y_out          = y;
    res.carry_out      = c;
    res.half_carry_out = h;
    res.overflow_out   = v;
    res.zero_flag      = (flag_byte == 8'h00);
    res.negative_flag  = flag_byte[7];
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  always @(posedge clk_i) begin
    mdba_out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_q.size() == 0) begin
          $error("unexpected result acc_out=%0h y_out=%0h", out_data_i.acc_out,
                 out_data_i.y_out);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = predicted_q.pop_front();
          checked_o = checked_o + 1;
          if (out_data_i.acc_out !== want.acc_out) begin
            $error("acc_out expected %0h got %0h", want.acc_out, out_data_i.acc_out);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i.y_out !== want.y_out) begin
            $error("y_out expected %0h got %0h", want.y_out, out_data_i.y_out);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i.carry_out !== want.carry_out) begin
            $error("carry_out expected %0b got %0b", want.carry_out,
                   out_data_i.carry_out);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i.half_carry_out !== want.half_carry_out) begin
            $error("half_carry_out expected %0b got %0b", want.half_carry_out,
                   out_data_i.half_carry_out);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i.overflow_out !== want.overflow_out) begin
            $error("overflow_out expected %0b got %0b", want.overflow_out,
                   out_data_i.overflow_out);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i.zero_flag !== want.zero_flag) begin
            $error("zero_flag expected %0b got %0b", want.zero_flag,
                   out_data_i.zero_flag);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i.negative_flag !== want.negative_flag) begin
            $error("negative_flag expected %0b got %0b", want.negative_flag,
                   out_data_i.negative_flag);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predicted_q.push_back(predict_result(in_data_i));
      pending_o = predicted_q.size();
    end
  end

endmodule

FILE: test/mul_div_bcd_adjust_unit_tb.sv
// ----------------------------------------------------------------------------
// mul_div_bcd_adjust_unit_tb
// drives directed corner cases and shaped random operations into the unit with
// random gaps and output stalls; the checker beside the block scores results
// ----------------------------------------------------------------------------
module mul_div_bcd_adjust_unit_tb;
  import mdba_pkg::*;

  localparam int RandomItems = 1450;
  localparam int CycleLimit  = 600000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  mdba_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  mdba_out_t out_data_o;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int sent_per_op[8];
  int quiet_items = 0;
  int stall_left  = 0;
  int calm_left   = 0;

  mul_div_bcd_adjust_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  mul_div_bcd_adjust_unit_chk u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver back-pressure: mostly short stalls, a few long, and calm stretches
  always @(negedge clk_i) begin
    logic nxt;
    int   roll;
    nxt = 1'b0;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      nxt = 1'b1;
    end else if (calm_left > 0) begin
      calm_left = calm_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        nxt = 1'b0;
      end else if (roll < 85) begin
        stall_left = $urandom_range(0, 2);
        nxt = 1'b1;
      end else if (roll < 95) begin
        calm_left = $urandom_range(20, 80);
      end else begin
        stall_left = $urandom_range(10, 60);
        nxt = 1'b1;
      end
    end
    out_stall_i <= nxt;
  end

  function automatic int pick_gap();
    int roll;
    if (quiet_items > 0) begin
      quiet_items = quiet_items - 1;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 93) return $urandom_range(4, 10);
    if (roll < 97) begin
      quiet_items = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic mdba_in_t mk_item(input logic [2:0] op, input logic [7:0] a,
                                       input logic [7:0] x, input logic [7:0] y,
                                       input logic c, input logic h, input logic v);
    mdba_in_t item;
    item.operation     = op;
    item.acc_in        = a;
    item.x_in          = x;
    item.y_in          = y;
    item.carry_in      = c;
    item.half_carry_in = h;
    item.overflow_in   = v;
    return item;
  endfunction

  function automatic logic [7:0] rand_byte();
    int roll;
    logic [7:0] picks[7];
    picks = '{8'h7f, 8'h80, 8'h01, 8'h99, 8'h9a, 8'h0f, 8'hf0};
    roll = $urandom_range(0, 99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hff;
    if (roll < 30) return picks[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic mdba_in_t random_item();
    mdba_in_t    item;
    int          roll;
    int unsigned xv;
    int unsigned top;
    item = mk_item(3'($urandom_range(0, 4)), rand_byte(), rand_byte(), rand_byte(),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 5) item.operation = 3'($urandom_range(5, 7));
    case (item.operation)
      OP_DIV: begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          // ordinary quotient and remainder: y below twice x
          xv = item.x_in;
          if (xv == 0) xv = $urandom_range(1, 255);
          top = (2 * xv - 1 > 255) ? 255 : 2 * xv - 1;
          item.x_in = 8'(xv);
          item.y_in = 8'($urandom_range(0, top));
        end else if (roll < 80) begin
          xv = $urandom_range(0, 127);
          item.x_in = 8'(xv);
          item.y_in = 8'($urandom_range(2 * xv, 255));
        end
      end
      OP_DAA, OP_DAS: begin
        if ($urandom_range(0, 99) < 40)
          item.acc_in = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      end
      default: begin
      end
    endcase
    return item;
  endfunction

  task automatic send_op(input mdba_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_per_op[item.operation] = sent_per_op[item.operation] + 1;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    mdba_in_t directed[$];
    foreach (sent_per_op[i]) sent_per_op[i] = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // multiply extremes, negative high byte
    directed.push_back(mk_item(OP_MUL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_MUL, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk_item(OP_MUL, 8'h02, 8'h5a, 8'h80, 1'b0, 1'b1, 1'b0));
    // divide: ordinary, zero divisor, quirky formula, boundaries
    directed.push_back(mk_item(OP_DIV, 8'h34, 8'h56, 8'h12, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DIV, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk_item(OP_DIV, 8'hff, 8'h00, 8'hff, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DIV, 8'hff, 8'h10, 8'hff, 1'b0, 1'b1, 1'b0));
    directed.push_back(mk_item(OP_DIV, 8'h00, 8'h40, 8'h40, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DIV, 8'hff, 8'h40, 8'h7f, 1'b0, 1'b0, 1'b1));
    directed.push_back(mk_item(OP_DIV, 8'h00, 8'h40, 8'h80, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DIV, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DIV, 8'h01, 8'h0f, 8'h03, 1'b0, 1'b1, 1'b1));
    // decimal adjust after add
    directed.push_back(mk_item(OP_DAA, 8'h99, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DAA, 8'h9a, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DAA, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DAA, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
    directed.push_back(mk_item(OP_DAA, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1));
    // decimal adjust after subtract
    directed.push_back(mk_item(OP_DAS, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    directed.push_back(mk_item(OP_DAS, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_DAS, 8'hfa, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    directed.push_back(mk_item(OP_DAS, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 1'b1));
    // nibble swap
    directed.push_back(mk_item(OP_XCN, 8'ha5, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk_item(OP_XCN, 8'h00, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk_item(OP_XCN, 8'h08, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    // unused codes pass everything through
    directed.push_back(mk_item(3'd5, 8'h80, 8'h12, 8'h34, 1'b1, 1'b0, 1'b1));
    directed.push_back(mk_item(3'd6, 8'h00, 8'hff, 8'hff, 1'b0, 1'b1, 1'b0));
    directed.push_back(mk_item(3'd7, 8'hff, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
    foreach (directed[i]) send_op(directed[i]);

    in_valid_i <= 1'b0;
    wait_drained();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) begin
        in_valid_i <= 1'b0;
        wait_drained();
        @(negedge clk_i);
      end
      send_op(random_item());
    end
    in_valid_i <= 1'b0;

    wait_drained();
    // keep running idle so a stray result would still be caught
    repeat (40) @(negedge clk_i);

    $display("sent mul %0d, div %0d, daa %0d, das %0d, xcn %0d, unused codes %0d",
             sent_per_op[OP_MUL], sent_per_op[OP_DIV], sent_per_op[OP_DAA],
             sent_per_op[OP_DAS], sent_per_op[OP_XCN],
             sent_per_op[5] + sent_per_op[6] + sent_per_op[7]);
    $display("%0d results compared under random gaps and stalls, %0d mismatches",
             checked, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
